### rtl/jdk_pkg.sv
// jdk_pkg: shared types and constants for the joystick to d-pad key block
// holds the payload structs, config bundle, job struct and register index codes
// no dependencies
`timescale 1ns / 1ps

package jdk_pkg;

  localparam int COORD_BITS    = 8;
  localparam int TIME_BITS     = 32;
  localparam int NKEYS         = 7;
  localparam int KEY_BITS      = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int QUEUE_DEPTH   = 2;
  // compare width: wide enough for coordinates and for the negated release level
  localparam int CMP_BITS      = ((COORD_BITS > 8) ? COORD_BITS : 8) + 2;

  localparam int KEY_UP       = 0;
  localparam int KEY_RIGHT    = 1;
  localparam int KEY_DOWN     = 2;
  localparam int KEY_LEFT     = 3;
  localparam int KEY_UPLEFT   = 4;
  localparam int KEY_UPRIGHT  = 5;
  localparam int KEY_BUTTON   = 6;

  localparam logic [1:0] BTN_RELEASED = 2'd0;
  localparam logic [1:0] BTN_PRESSED  = 2'd1;

  localparam logic EV_PRESS  = 1'b0;
  localparam logic EV_REPEAT = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PRESS_THRESHOLD    = 3'd0,
    REG_RELEASE_LEVEL      = 3'd1,
    REG_LONG_PRESS_MS      = 3'd2,
    REG_REPEAT_INTERVAL_MS = 3'd3,
    REG_REPEAT_ENABLE_MASK = 3'd4,
    REG_EVENT_ENABLE       = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] axis_x;
    logic signed [COORD_BITS-1:0] axis_y;
    logic [1:0]                   button_code;
    logic [31:0]                  now_ms;
  } in_item_t;

  typedef struct packed {
    logic [NKEYS-1:0]    pressed_mask;
    logic [NKEYS-1:0]    long_mask;
    logic                event_valid;
    logic [KEY_BITS-1:0] event_key;
    logic                event_kind;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [6:0]        press_threshold;
    logic signed [7:0] release_level;
    logic [15:0]       long_press_ms;
    logic [15:0]       repeat_interval_ms;
    logic [NKEYS-1:0]  repeat_enable_mask;
    logic              event_enable;
  } cfg_t;

  typedef struct packed {
    logic [NKEYS-1:0] pressed;
    logic [NKEYS-1:0] long_held;
    logic [NKEYS-1:0] press_ev;
    logic [NKEYS-1:0] repeat_ev;
  } job_t;

endpackage

### rtl/jdk_regs.sv
// jdk_regs: configuration register file
// depends on jdk_pkg for cfg_t and the register index codes
`timescale 1ns / 1ps

module jdk_regs import jdk_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                     cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_threshold    <= 7'd100;
      cfg_r.release_level      <= 8'sd40;
      cfg_r.long_press_ms      <= 16'd500;
      cfg_r.repeat_interval_ms <= 16'd100;
      cfg_r.repeat_enable_mask <= '0;
      cfg_r.event_enable       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PRESS_THRESHOLD:    cfg_r.press_threshold    <= cfg_data[6:0];
        REG_RELEASE_LEVEL:      cfg_r.release_level      <= $signed(cfg_data[7:0]);
        REG_LONG_PRESS_MS:      cfg_r.long_press_ms      <= cfg_data;
        REG_REPEAT_INTERVAL_MS: cfg_r.repeat_interval_ms <= cfg_data;
        REG_REPEAT_ENABLE_MASK: cfg_r.repeat_enable_mask <= cfg_data[NKEYS-1:0];
        REG_EVENT_ENABLE:       cfg_r.event_enable       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/jdk_front.sv
// jdk_front: accepts samples, runs key hysteresis and timing, builds event jobs
// depends on jdk_pkg; feeds jobs into jdk_queue
`timescale 1ns / 1ps

module jdk_front import jdk_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     job_valid,
  output job_t     job,
  input  logic     job_full
);

  logic                        accept;
  logic                        push;
  logic signed [CMP_BITS-1:0]  x, y, t, q, e, d;
  logic [NKEYS-1:0]            on, off, kd_new, rise;
  logic [TIME_BITS-1:0]        now;

  logic [NKEYS-1:0]            key_down_r;
  logic [TIME_BITS-1:0]        press_time_r [NKEYS];
  logic [TIME_BITS-1:0]        last_scan_r;
  logic                        s1_valid_r;
  logic [NKEYS-1:0]            s1_kd_r;
  logic [NKEYS-1:0]            s1_rise_r;
  logic [TIME_BITS-1:0]        s1_now_r;

  logic [NKEYS-1:0]            long_m;
  logic                        scan;
  logic [TIME_BITS-1:0]        diff [NKEYS];
  logic [TIME_BITS-1:0]        scan_diff;

  assign in_stall = s1_valid_r && job_full;
  assign accept   = in_valid && !in_stall;
  assign push     = s1_valid_r && !job_full;

  // classify the sample
  always_comb begin
    x   = CMP_BITS'(in_data.axis_x);
    y   = CMP_BITS'(in_data.axis_y);
    t   = $signed({{(CMP_BITS-7){1'b0}}, cfg.press_threshold});
    q   = t >>> 2;
    e   = t >>> 3;
    d   = CMP_BITS'(cfg.release_level);
    now = TIME_BITS'(in_data.now_ms);

    on[KEY_UP]       = (y > t) && (x > -q) && (x < q);
    off[KEY_UP]      = y < d;
    on[KEY_RIGHT]    = (x > t) && (y > -q) && (y < q);
    off[KEY_RIGHT]   = x < d;
    on[KEY_DOWN]     = y < -t;
    off[KEY_DOWN]    = y > -d;
    on[KEY_LEFT]     = (x < -t) && (y > -q) && (y < q);
    off[KEY_LEFT]    = x > -d;
    on[KEY_UPLEFT]   = (y > t) && (x < -e);
    off[KEY_UPLEFT]  = y < d;
    on[KEY_UPRIGHT]  = (y > t) && (x > e);
    off[KEY_UPRIGHT] = y < d;
    on[KEY_BUTTON]   = in_data.button_code == BTN_PRESSED;
    off[KEY_BUTTON]  = in_data.button_code == BTN_RELEASED;

    for (int i = 0; i < NKEYS; i++) begin
      kd_new[i] = on[i] || (key_down_r[i] && !off[i]);
    end
    rise = kd_new & ~key_down_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_down_r  <= '0;
      last_scan_r <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        key_down_r <= kd_new;
        s1_valid_r <= 1'b1;
      end else if (push) begin
        s1_valid_r <= 1'b0;
      end
      if (push && scan) begin
        last_scan_r <= s1_now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kd_r   <= kd_new;
      s1_rise_r <= rise;
      s1_now_r  <= now;
      for (int i = 0; i < NKEYS; i++) begin
        if (rise[i]) begin
          press_time_r[i] <= now;
        end
      end
    end
  end

  // hold times and repeat scan
  always_comb begin
    for (int i = 0; i < NKEYS; i++) begin
      diff[i]   = s1_now_r - press_time_r[i];
      long_m[i] = s1_kd_r[i] && (diff[i] >= TIME_BITS'(cfg.long_press_ms));
    end
    scan_diff = s1_now_r - last_scan_r;
    scan      = scan_diff >= TIME_BITS'(cfg.repeat_interval_ms);

    job.pressed   = s1_kd_r;
    job.long_held = long_m;
    job.press_ev  = cfg.event_enable ? s1_rise_r : '0;
    job.repeat_ev = (cfg.event_enable && scan) ? (cfg.repeat_enable_mask & long_m) : '0;
  end

  assign job_valid = push;

endmodule

### rtl/jdk_queue.sv
// jdk_queue: short fifo of event jobs between front and back
// depends on jdk_pkg for job_t and QUEUE_DEPTH
`timescale 1ns / 1ps

module jdk_queue import jdk_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  output logic q_valid,
  output job_t q_data,
  input  logic pop
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  job_t                mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0] count_r;
  logic                do_pop;

  assign full    = count_r == CNT_BITS'(QUEUE_DEPTH);
  assign q_valid = count_r != '0;
  assign q_data  = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/jdk_emit.sv
// jdk_emit: walks each job's events, one beat per cycle unless stalled
// depends on jdk_pkg; drains jdk_queue and drives the result register
`timescale 1ns / 1ps

module jdk_emit import jdk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  job_t      q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  job_t                cur_r;
  logic                cur_valid_r;
  out_item_t           out_data_r;
  logic                out_valid_r;

  logic                out_ready;
  logic                emit;
  logic                sel_press, sel_any;
  logic [KEY_BITS-1:0] sel_key;
  logic [NKEYS-1:0]    press_left, repeat_left;
  logic                is_last;
  out_item_t           beat;

  assign out_ready = !out_valid_r || !out_stall;
  assign emit      = cur_valid_r && out_ready;

  always_comb begin
    sel_press = cur_r.press_ev != '0;
    sel_any   = sel_press || (cur_r.repeat_ev != '0);
    sel_key   = '0;
    for (int i = NKEYS - 1; i >= 0; i--) begin
      if (sel_press ? cur_r.press_ev[i] : cur_r.repeat_ev[i]) begin
        sel_key = KEY_BITS'(i);
      end
    end
    press_left  = cur_r.press_ev;
    repeat_left = cur_r.repeat_ev;
    if (sel_press) begin
      press_left[sel_key] = 1'b0;
    end else if (sel_any) begin
      repeat_left[sel_key] = 1'b0;
    end
    is_last = (press_left == '0) && (repeat_left == '0);

    beat.pressed_mask = cur_r.pressed;
    beat.long_mask    = cur_r.long_held;
    beat.event_valid  = sel_any;
    beat.event_key    = sel_key;
    beat.event_kind   = (sel_any && !sel_press) ? EV_REPEAT : EV_PRESS;
    beat.last         = is_last;
  end

  assign q_pop = q_valid && (!cur_valid_r || (emit && is_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
      end else if (emit && is_last) begin
        cur_valid_r <= 1'b0;
      end
      if (out_ready) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end else if (emit) begin
      cur_r.press_ev  <= press_left;
      cur_r.repeat_ev <= repeat_left;
    end
    if (emit) begin
      out_data_r <= beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/joystick_to_dpad_keys.sv
// joystick_to_dpad_keys: joystick samples to seven virtual keys with press and repeat events
// first beat path: s1 stage register, job queue, current-job register, result register
// throughput: one result beat per cycle from the emit stage unless out_stall holds it; a
//   sample yields max(1, press events + repeat events) beats, at most 14, a quiet sample one
// reset: synchronous active-low rst_n clears key state, scan time, queue and valid flags;
//   press times need no reset and config returns to its default values
`timescale 1ns / 1ps

module joystick_to_dpad_keys import jdk_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data
);

  cfg_t cfg;
  logic job_valid, job_full;
  job_t job;
  logic q_valid, q_pop;
  job_t q_data;

  jdk_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jdk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job       (job),
    .job_full  (job_full)
  );

  jdk_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_valid),
    .push_data (job),
    .full      (job_full),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (q_pop)
  );

  jdk_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### verif/jdk_key_checker.sv
// jdk_key_checker: predicts the key masks and event beats of joystick_to_dpad_keys
// and compares every result beat against them; depends on jdk_pkg only
`timescale 1ns / 1ps

module jdk_key_checker import jdk_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  in_item_t                 in_data,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  out_item_t                out_data,
  output int                       errors,
  output int                       outstanding
);

  cfg_t             regs;
  logic [NKEYS-1:0] held;
  logic [31:0]      pressed_at [NKEYS];
  logic [31:0]      scan_at;
  out_item_t        key_beats_q[$];
  out_item_t        want;

  function automatic logic [NKEYS-1:0] steer(logic [NKEYS-1:0] m, int k, bit on, bit off);
    if (on) begin
      m[k] = 1'b1;
    end else if (off) begin
      m[k] = 1'b0;
    end
    return m;
  endfunction

  task automatic predict_key_beats(in_item_t s);
    int               x;
    int               y;
    int               t;
    int               q;
    int               e;
    int               d;
    logic [NKEYS-1:0] now_down;
    logic [NKEYS-1:0] rising;
    logic [NKEYS-1:0] long_held;
    logic [31:0]      age;
    out_item_t        beats[$];
    out_item_t        b;
    x = $signed(s.axis_x);
    y = $signed(s.axis_y);
    t = regs.press_threshold;
    q = t / 4;
    e = t / 8;
    d = $signed(regs.release_level);
    now_down = held;
    now_down = steer(now_down, KEY_UP, y > t && x > -q && x < q, y < d);
    now_down = steer(now_down, KEY_RIGHT, x > t && y > -q && y < q, x < d);
    now_down = steer(now_down, KEY_LEFT, x < -t && y > -q && y < q, x > -d);
    now_down = steer(now_down, KEY_DOWN, y < -t, y > -d);
    now_down = steer(now_down, KEY_UPLEFT, y > t && x < -e, y < d);
    now_down = steer(now_down, KEY_UPRIGHT, y > t && x > e, y < d);
    now_down = steer(now_down, KEY_BUTTON, s.button_code == BTN_PRESSED,
                     s.button_code == BTN_RELEASED);
    rising = now_down & ~held;
    held = now_down;
    long_held = '0;
    for (int i = 0; i < NKEYS; i++) begin
      if (rising[i]) pressed_at[i] = s.now_ms;
      age = s.now_ms - pressed_at[i];
      long_held[i] = now_down[i] && (age >= 32'(regs.long_press_ms));
    end
    b = '0;
    b.pressed_mask = now_down;
    b.long_mask = long_held;
    b.event_valid = 1'b1;
    if (regs.event_enable) begin
      for (int i = 0; i < NKEYS; i++) begin
        if (rising[i]) begin
          b.event_key = KEY_BITS'(i);
          b.event_kind = EV_PRESS;
          beats.push_back(b);
        end
      end
    end
    age = s.now_ms - scan_at;
    if (age >= 32'(regs.repeat_interval_ms)) begin
      for (int i = 0; i < NKEYS; i++) begin
        if (regs.event_enable && regs.repeat_enable_mask[i] && long_held[i]) begin
          b.event_key = KEY_BITS'(i);
          b.event_kind = EV_REPEAT;
          beats.push_back(b);
        end
      end
      scan_at = s.now_ms;
    end
    if (beats.size() == 0) begin
      b.event_valid = 1'b0;
      b.event_key = '0;
      b.event_kind = EV_PRESS;
      beats.push_back(b);
    end
    foreach (beats[i]) begin
      b = beats[i];
      b.last = (i == beats.size() - 1);
      key_beats_q.push_back(b);
    end
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs = '{press_threshold: 7'd100, release_level: 8'sd40, long_press_ms: 16'd500,
               repeat_interval_ms: 16'd100, repeat_enable_mask: '0, event_enable: 1'b0};
      held = '0;
      scan_at = '0;
      key_beats_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PRESS_THRESHOLD:    regs.press_threshold = cfg_data[6:0];
          REG_RELEASE_LEVEL:      regs.release_level = cfg_data[7:0];
          REG_LONG_PRESS_MS:      regs.long_press_ms = cfg_data;
          REG_REPEAT_INTERVAL_MS: regs.repeat_interval_ms = cfg_data;
          REG_REPEAT_ENABLE_MASK: regs.repeat_enable_mask = cfg_data[NKEYS-1:0];
          REG_EVENT_ENABLE:       regs.event_enable = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_key_beats(in_data);
      if (out_valid && !out_stall) begin
        if (key_beats_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, expected none, actual %h",
                   $time, out_data);
        end else begin
          want = key_beats_q.pop_front();
          check_field("pressed_mask", 32'(want.pressed_mask), 32'(out_data.pressed_mask));
          check_field("long_mask", 32'(want.long_mask), 32'(out_data.long_mask));
          check_field("event_valid", 32'(want.event_valid), 32'(out_data.event_valid));
          check_field("event_key", 32'(want.event_key), 32'(out_data.event_key));
          check_field("event_kind", 32'(want.event_kind), 32'(out_data.event_kind));
          check_field("last", 32'(want.last), 32'(out_data.last));
        end
      end
    end
    outstanding <= key_beats_q.size();
  end

endmodule

### verif/tb_joystick_to_dpad_keys.sv
// tb_joystick_to_dpad_keys: drives joystick samples, config phases and output stalls
// into joystick_to_dpad_keys; depends on jdk_pkg and jdk_key_checker for the verdict
`timescale 1ns / 1ps

module tb_joystick_to_dpad_keys;
  import jdk_pkg::*;

  localparam logic [1:0] BTN_KEEP      = 2'd2;
  localparam logic [1:0] BTN_KEEP_ALT  = 2'd3;
  localparam int         SETTLE_CYCLES = 8;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  in_item_t                 in_data;
  logic                     out_valid;
  logic                     out_stall;
  out_item_t                out_data;
  int                       errors;
  int                       outstanding;
  cfg_t                     settings;
  logic [31:0]              clock_ms;
  bit                       eager_in;
  bit                       eager_out;

  joystick_to_dpad_keys dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  jdk_key_checker key_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int rand_range(int lo, int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic [7:0] coord(int v);
    if (v > 127) v = 127;
    else if (v < -128) v = -128;
    return v[7:0];
  endfunction

  function automatic cfg_t mk_cfg(int t, int d, int hold_ms, int gap_ms, int mask, bit ev);
    cfg_t c;
    c.press_threshold = t[6:0];
    c.release_level = d[7:0];
    c.long_press_ms = hold_ms[15:0];
    c.repeat_interval_ms = gap_ms[15:0];
    c.repeat_enable_mask = mask[NKEYS-1:0];
    c.event_enable = ev;
    return c;
  endfunction

  task automatic put_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic load_settings(cfg_t c);
    put_reg(REG_PRESS_THRESHOLD, 16'(c.press_threshold));
    put_reg(REG_RELEASE_LEVEL, {8'h00, c.release_level});
    put_reg(REG_LONG_PRESS_MS, c.long_press_ms);
    put_reg(REG_REPEAT_INTERVAL_MS, c.repeat_interval_ms);
    put_reg(REG_REPEAT_ENABLE_MASK, 16'(c.repeat_enable_mask));
    put_reg(REG_EVENT_ENABLE, 16'(c.event_enable));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings = c;
  endtask

  // wait for every expected beat, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_sample(int xv, int yv, logic [1:0] code, logic [31:0] at);
    in_item_t s;
    int       gap;
    s.axis_x = coord(xv);
    s.axis_y = coord(yv);
    s.button_code = code;
    s.now_ms = at;
    if ($urandom_range(0, 11) == 0) eager_in = !eager_in;
    gap = eager_in ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stick position that holds or presses one direction key
  task automatic make_hold(input int dir, input bit mid, output int xv, output int yv);
    int t;
    int q;
    int e;
    int d;
    int lvl;
    t = settings.press_threshold;
    q = t / 4;
    e = t / 8;
    d = $signed(settings.release_level);
    lvl = mid ? rand_range(d, t) : rand_range(t + 1, 128);
    case (dir)
      KEY_UP: begin
        yv = lvl;
        xv = rand_range(1 - q, q - 1);
      end
      KEY_RIGHT: begin
        xv = lvl;
        yv = rand_range(1 - q, q - 1);
      end
      KEY_DOWN: begin
        yv = -lvl;
        xv = rand_range(-128, 127);
      end
      KEY_LEFT: begin
        xv = -lvl;
        yv = rand_range(1 - q, q - 1);
      end
      KEY_UPLEFT: begin
        yv = lvl;
        xv = -rand_range(e + 1, 128);
      end
      default: begin
        yv = lvl;
        xv = rand_range(e + 1, 128);
      end
    endcase
  endtask

  task automatic run_phase(cfg_t c, int n);
    int done;
    int len;
    int dir;
    int xv;
    int yv;
    int step_max;
    settle();
    load_settings(c);
    step_max = int'(c.long_press_ms) / 3 + int'(c.repeat_interval_ms) / 2 + 40;
    done = 0;
    while (done < n) begin
      if ($urandom_range(0, 9) < 7) begin
        dir = $urandom_range(KEY_UP, KEY_UPRIGHT);
        len = $urandom_range(2, 7);
        for (int k = 0; k < len; k++) begin
          make_hold(dir, k > 0 && $urandom_range(0, 3) == 0, xv, yv);
          clock_ms += $urandom_range(0, step_max);
          send_sample(xv, yv, 2'($urandom_range(0, 3)), clock_ms);
        end
        clock_ms += $urandom_range(0, step_max);
        send_sample(rand_range(-16, 16), rand_range(-16, 16), 2'($urandom_range(0, 3)),
                    clock_ms);
        done += len + 1;
      end else begin
        if ($urandom_range(0, 3) == 0) clock_ms = $urandom();
        else clock_ms += $urandom_range(0, step_max);
        send_sample(rand_range(-128, 127), rand_range(-128, 127), 2'($urandom_range(0, 3)),
                    clock_ms);
        done++;
      end
    end
  endtask

  initial begin : receiver
    int hold_n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 11) == 0) eager_out = !eager_out;
      hold_n = eager_out ? 0 : $urandom_range(0, 13);
      if (hold_n > 0) begin
        out_stall <= 1'b1;
        repeat (hold_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    clock_ms = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: events off, state still tracks
    send_sample(0, 0, BTN_KEEP, 32'd0);
    send_sample(0, 127, BTN_PRESSED, 32'd600);
    send_sample(0, 0, BTN_RELEASED, 32'd700);

    // zero long press and zero interval: press and repeat in the same sample
    settle();
    load_settings(mk_cfg(100, 40, 0, 0, 127, 1'b1));
    send_sample(0, 0, BTN_KEEP, 32'd0);
    send_sample(0, 127, BTN_PRESSED, 32'd10);
    send_sample(0, 127, BTN_KEEP_ALT, 32'd20);
    send_sample(127, 0, BTN_RELEASED, 32'd30);
    send_sample(-128, 0, BTN_KEEP, 32'd40);
    send_sample(0, -128, BTN_KEEP, 32'd50);
    send_sample(-128, 127, BTN_PRESSED, 32'hFFFF_FFF0);
    send_sample(127, 127, BTN_KEEP, 32'hFFFF_FFFF);
    send_sample(127, -128, BTN_KEEP, 32'd5);
    send_sample(-128, -128, BTN_RELEASED, 32'h8000_0000);
    send_sample(70, 70, BTN_KEEP, 32'h8000_0001);
    send_sample(0, 0, BTN_KEEP_ALT, 32'h8000_0002);

    clock_ms = 32'd1000;
    run_phase(mk_cfg(100, 40, 500, 100, 127, 1'b1), 30);
    run_phase(mk_cfg(127, -128, 65535, 65535, 0, 1'b1), 25);
    run_phase(mk_cfg(0, 127, 0, 0, 127, 1'b1), 30);
    run_phase(mk_cfg($urandom_range(0, 127), rand_range(-128, 127), $urandom_range(0, 1000),
                     $urandom_range(0, 300), $urandom_range(0, 127), 1'b0), 25);
    run_phase(mk_cfg(20, -20, 200, 50, 127, 1'b1), 30);
    run_phase(mk_cfg($urandom_range(0, 127), rand_range(-128, 127), $urandom_range(0, 1000),
                     $urandom_range(0, 300), $urandom_range(0, 127), 1'b1), 30);
    run_phase(mk_cfg(60, 10, 300, 0, $urandom_range(0, 127), 1'b1), 30);
    settle();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/jdk_pkg.sv
rtl/jdk_regs.sv
rtl/jdk_front.sv
rtl/jdk_queue.sv
rtl/jdk_emit.sv
rtl/joystick_to_dpad_keys.sv
verif/jdk_key_checker.sv
verif/tb_joystick_to_dpad_keys.sv
